[sv/block_buffer_cache_lru_core_assert.svh]
// Assertion macros for the block buffer cache checker.
// No dependencies; take in by include inside a module body that has clk_i and rst_ni.
`ifndef BLOCK_BUFFER_CACHE_LRU_CORE_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_LRU_CORE_ASSERT_SVH

// Clocked check, held off while reset is asserted.
`define BBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also runs during reset.
`define BBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/bbc_pkg.sv]
// Shared types and constants for the block buffer cache.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package bbc_pkg;

  localparam int unsigned ENTRIES_DEF = 32;
  localparam int unsigned DEV_W       = 8;
  localparam int unsigned BLK_W       = 32;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned STAMP_BIT_W = 5;
  localparam int unsigned CNT_W       = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    CMD_GET     = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_PIN     = 3'd2,
    CMD_UNPIN   = 3'd3,
    CMD_VALID   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NOFREE = 2'd1,
    STAT_UNDER  = 2'd2,
    STAT_OVER   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_LOOK   = 2'd1,
    ST_SCAN   = 2'd2,
    ST_COMMIT = 2'd3
  } state_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [DEV_W-1:0]   device;
    logic [BLK_W-1:0]   block_number;
    logic [IDX_W-1:0]   entry_index;
    logic [STAMP_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] entry_out;
    logic             hit;
    logic             needs_read;
    logic [1:0]       status;
  } rsp_t;

  typedef struct packed {
    logic                   load;
    logic                   look;
    logic                   scan;
    logic                   commit;
    logic [STAMP_BIT_W-1:0] bit_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_get;
    logic any_match;
    logic any_cand;
    logic out_busy;
  } dp_stat_t;

endpackage

[sv/block_buffer_cache_lru_core.sv]
// Channel  Direction  Handshake               Word
// in       input      in_valid_i / in_stall_o  bbc_pkg::req_t (command, tag, index, now)
// out      output     out_valid_o / out_stall_i bbc_pkg::rsp_t (entry, hit, read, status)
//
// Release, pin, unpin, mark valid and a get that hits or finds no free entry go from
// lookup straight to commit; the result is registered at commit, then the next word is taken.
// A get that misses with a free entry runs a scan between lookup and commit:
// a 32-step scan over the stamp bits, one bit per cycle across all entries.
// One word is in flight at a time; a result held by out_stall_i delays the next commit.
// Reset sets every tag to all ones and clears counts, stamps and valid marks at once.
// Top level of the block buffer cache; depends on bbc_pkg, bbc_ctrl and bbc_dp.
`timescale 1ns / 1ps

module block_buffer_cache_lru_core #(
  parameter int unsigned ENTRIES = bbc_pkg::ENTRIES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bbc_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bbc_pkg::rsp_t out_data_o
);
  import bbc_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  bbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  bbc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

[sv/bbc_ctrl.sv]
// Sequencer for the block buffer cache: accept, tag lookup, stamp scan, commit.
// Depends on bbc_pkg; drives the datapath bbc_dp through dp_cmd_t.
`timescale 1ns / 1ps

module bbc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bbc_pkg::dp_stat_t stat_i,
  output bbc_pkg::dp_cmd_t  cmd_o
);
  import bbc_pkg::*;

  state_e                 state_q, state_d;
  logic [STAMP_BIT_W-1:0] bit_q, bit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
    end
  end

  always_comb begin
    state_d = state_q;
    bit_d   = bit_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        // miss with a free entry: walk the stamps from the top bit down
        if (stat_i.is_get && !stat_i.any_match && stat_i.any_cand) begin
          state_d = ST_SCAN;
          bit_d   = STAMP_BIT_W'(STAMP_W - 1);
        end else begin
          state_d = ST_COMMIT;
        end
      end
      ST_SCAN: begin
        if (bit_q == '0) state_d = ST_COMMIT;
        else bit_d = bit_q - 1'b1;
      end
      ST_COMMIT: begin
        if (!stat_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = (state_q != ST_IDLE);
    cmd_o.load    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.look    = (state_q == ST_LOOK);
    cmd_o.scan    = (state_q == ST_SCAN);
    cmd_o.commit  = (state_q == ST_COMMIT) && !stat_i.out_busy;
    cmd_o.bit_sel = bit_q;
  end

endmodule

[sv/bbc_dp.sv]
// Datapath of the block buffer cache: entry table, tag match, oldest-free search,
// entry update and result register. Depends on bbc_pkg; sequenced by bbc_ctrl.
`timescale 1ns / 1ps

module bbc_dp #(
  parameter int unsigned ENTRIES = bbc_pkg::ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bbc_pkg::req_t     in_data_i,
  input  bbc_pkg::dp_cmd_t  cmd_i,
  output bbc_pkg::dp_stat_t stat_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output bbc_pkg::rsp_t     out_data_o
);
  import bbc_pkg::*;

  localparam int unsigned IdxW = $clog2(ENTRIES);

  req_t req_q;

  logic [DEV_W-1:0]   tag_dev_q [ENTRIES];
  logic [BLK_W-1:0]   tag_blk_q [ENTRIES];
  logic [CNT_W-1:0]   cnt_q     [ENTRIES];
  logic [STAMP_W-1:0] stamp_q   [ENTRIES];
  logic               vld_q     [ENTRIES];

  logic [ENTRIES-1:0] match, free, at_max, at_one, vld_v, dec_sel, zero_bits;
  logic [ENTRIES-1:0] match_lo, cand_lo, sel;
  logic [ENTRIES-1:0] sel_q, cand_q;
  logic               use_cand_q;
  logic               is_get;
  logic [IdxW-1:0]    enc;

  logic alloc, inc, dec, stamp_en, set_vld;
  rsp_t rsp;
  logic out_valid_q;
  rsp_t out_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_data_i;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign match[i]     = (tag_dev_q[i] == req_q.device) &&
                          (tag_blk_q[i] == req_q.block_number);
    assign free[i]      = (cnt_q[i] == '0);
    assign at_max[i]    = (cnt_q[i] == CNT_MAX);
    assign at_one[i]    = (cnt_q[i] == CNT_W'(1));
    assign vld_v[i]     = vld_q[i];
    assign dec_sel[i]   = (32'(req_q.entry_index) == 32'(i));
    assign zero_bits[i] = cand_q[i] & ~stamp_q[i][cmd_i.bit_sel];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_dev_q[i] <= '1;
        tag_blk_q[i] <= '1;
        cnt_q[i]     <= '0;
        stamp_q[i]   <= '0;
        vld_q[i]     <= 1'b0;
      end else if (cmd_i.commit && sel[i]) begin
        if (alloc) begin
          tag_dev_q[i] <= req_q.device;
          tag_blk_q[i] <= req_q.block_number;
          cnt_q[i]     <= CNT_W'(1);
          stamp_q[i]   <= req_q.now;
          vld_q[i]     <= 1'b0;
        end else begin
          if (inc)      cnt_q[i]   <= cnt_q[i] + 1'b1;
          if (dec)      cnt_q[i]   <= cnt_q[i] - 1'b1;
          if (stamp_en) stamp_q[i] <= req_q.now;
          if (set_vld)  vld_q[i]   <= 1'b1;
        end
      end
    end
  end

  assign is_get   = (req_q.command == CMD_GET);
  assign match_lo = match & (~match + ENTRIES'(1));
  assign cand_lo  = cand_q & (~cand_q + ENTRIES'(1));

  // Lookup latches the addressed entry; the scan drops every candidate whose
  // stamp bit is set while some candidate has it clear.
  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      sel_q      <= is_get ? match_lo : dec_sel;
      cand_q     <= free;
      use_cand_q <= is_get && !(|match);
    end else if (cmd_i.scan && (|zero_bits)) begin
      cand_q <= zero_bits;
    end
  end

  assign sel = use_cand_q ? cand_lo : sel_q;

  always_comb begin
    enc = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      enc = enc | (IdxW'(i) & {IdxW{sel[i]}});
    end
  end

  always_comb begin
    alloc          = 1'b0;
    inc            = 1'b0;
    dec            = 1'b0;
    stamp_en       = 1'b0;
    set_vld        = 1'b0;
    rsp.entry_out  = req_q.entry_index;
    rsp.hit        = 1'b0;
    rsp.needs_read = 1'b0;
    rsp.status     = STAT_OK;
    unique case (req_q.command)
      CMD_GET: begin
        if (use_cand_q) begin
          if (!(|cand_q)) begin
            rsp.status    = STAT_NOFREE;
            rsp.entry_out = '0;
          end else begin
            alloc          = 1'b1;
            rsp.entry_out  = IDX_W'(enc);
            rsp.needs_read = 1'b1;
          end
        end else begin
          rsp.entry_out  = IDX_W'(enc);
          rsp.hit        = 1'b1;
          rsp.needs_read = !(|(sel & vld_v));
          if (|(sel & at_max)) begin
            rsp.status = STAT_OVER;
          end else begin
            inc      = 1'b1;
            stamp_en = 1'b1;
          end
        end
      end
      CMD_RELEASE, CMD_UNPIN: begin
        if (|(sel & free)) begin
          rsp.status = STAT_UNDER;
        end else begin
          dec      = 1'b1;
          stamp_en = (req_q.command == CMD_RELEASE) && (|(sel & at_one));
        end
      end
      CMD_PIN: begin
        if (|(sel & at_max)) rsp.status = STAT_OVER;
        else inc = 1'b1;
      end
      CMD_VALID: set_vld = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) out_data_q <= rsp;
  end

  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_data_q;
  assign stat_o.is_get    = is_get;
  assign stat_o.any_match = |match;
  assign stat_o.any_cand  = |free;
  assign stat_o.out_busy  = out_valid_q && out_stall_i;

endmodule

[sv/bbc_checker.sv]
// Port-level checks for the block buffer cache, bound to the top level.
// Depends on bbc_pkg and block_buffer_cache_lru_core_assert.svh.
`timescale 1ns / 1ps

module bbc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input bbc_pkg::rsp_t out_data_o
);
  import bbc_pkg::*;
  `include "block_buffer_cache_lru_core_assert.svh"

  `BBC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result word changed")
  `BBC_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o, "second word taken while one is in work")
  `BBC_ASSERT(a_hit_status, out_valid_o && out_data_o.hit |-> out_data_o.status == STAT_OK || out_data_o.status == STAT_OVER, "hit with a status only a miss or index command can give")
  `BBC_ASSERT(a_nofree_clean, out_valid_o && out_data_o.status == STAT_NOFREE |-> out_data_o.entry_out == '0 && !out_data_o.hit && !out_data_o.needs_read, "no-free result carries an entry")
  `BBC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind block_buffer_cache_lru_core bbc_checker u_bbc_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for block_buffer_cache_lru_core: drives get, release, pin, unpin,
// mark-valid and spare words, predicts every reply from a local copy of the buffer table.
// Depends on bbc_pkg and the block's top level only.

module tb_top;
  import bbc_pkg::*;

  localparam int unsigned ENTRIES = ENTRIES_DEF;
  localparam int unsigned TAG_POOL = 40;
  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [31:0] BLK_TOP = 32'hffff_fffe;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b1;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  req_t  in_data_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  rsp_t  out_data_o;

  // buffer table as the bench sees it
  logic [DEV_W-1:0]   tag_dev [ENTRIES];
  logic [BLK_W-1:0]   tag_blk [ENTRIES];
  logic [CNT_W-1:0]   refs    [ENTRIES];
  logic [STAMP_W-1:0] stamp   [ENTRIES];
  logic               filled  [ENTRIES];

  req_t req_backlog [$];
  rsp_t reply_due [$];
  rsp_t want;
  int   fault_count = 0;
  bit   in_taken = 1'b0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   gap_pct = 25;
  int   stall_pct = 25;
  logic [STAMP_W-1:0] tick = '0;
  logic [DEV_W-1:0]   pool_dev [TAG_POOL];
  logic [BLK_W-1:0]   pool_blk [TAG_POOL];

  block_buffer_cache_lru_core #(.ENTRIES(ENTRIES)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Apply one word to the table and return the reply it must produce.
  function automatic rsp_t predict_reply(req_t w);
    rsp_t r;
    int   hit_at;
    int   victim;
    logic [STAMP_W-1:0] oldest;
    r = '0;
    r.entry_out = w.entry_index;
    r.status = STAT_OK;
    hit_at = -1;
    victim = -1;
    oldest = '0;
    if (w.command == CMD_GET) begin
      r.entry_out = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit_at < 0 && tag_dev[i] == w.device && tag_blk[i] == w.block_number) hit_at = i;
      end
      if (hit_at >= 0) begin
        r.entry_out = IDX_W'(hit_at);
        r.hit = 1'b1;
        r.needs_read = !filled[hit_at];
        if (refs[hit_at] == CNT_MAX) begin
          r.status = STAT_OVER;
        end else begin
          refs[hit_at] = refs[hit_at] + 1'b1;
          stamp[hit_at] = w.now;
        end
      end else begin
        // oldest unreferenced entry, lowest index on equal stamps
        for (int i = 0; i < ENTRIES; i++) begin
          if (refs[i] == '0 && (victim < 0 || stamp[i] < oldest)) begin
            victim = i;
            oldest = stamp[i];
          end
        end
        if (victim < 0) begin
          r.status = STAT_NOFREE;
        end else begin
          tag_dev[victim] = w.device;
          tag_blk[victim] = w.block_number;
          stamp[victim] = w.now;
          filled[victim] = 1'b0;
          refs[victim] = CNT_W'(1);
          r.entry_out = IDX_W'(victim);
          r.needs_read = 1'b1;
        end
      end
    end else begin
      case (w.command)
        CMD_RELEASE, CMD_UNPIN: begin
          if (refs[w.entry_index] == '0) begin
            r.status = STAT_UNDER;
          end else begin
            refs[w.entry_index] = refs[w.entry_index] - 1'b1;
            if (w.command == CMD_RELEASE && refs[w.entry_index] == '0)
              stamp[w.entry_index] = w.now;
          end
        end
        CMD_PIN: begin
          if (refs[w.entry_index] == CNT_MAX) r.status = STAT_OVER;
          else refs[w.entry_index] = refs[w.entry_index] + 1'b1;
        end
        CMD_VALID: filled[w.entry_index] = 1'b1;
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic req_t make_word(logic [2:0] cmd, logic [DEV_W-1:0] dev,
                                     logic [BLK_W-1:0] blk, logic [IDX_W-1:0] idx,
                                     logic [STAMP_W-1:0] stamp_now);
    req_t w;
    w.command = cmd;
    w.device = dev;
    w.block_number = blk;
    w.entry_index = idx;
    w.now = stamp_now;
    return w;
  endfunction

  // Mostly a slowly advancing clock, sometimes a jump or an extreme.
  function automatic logic [STAMP_W-1:0] next_now();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 84) begin
      tick = tick + $urandom_range(0, 3);
      return tick;
    end
    if (roll < 92) return $urandom;
    if (roll < 96) return '0;
    return '1;
  endfunction

  function automatic logic [IDX_W-1:0] busy_entry();
    int picks [$];
    for (int i = 0; i < ENTRIES; i++) if (refs[i] != '0) picks.push_back(i);
    if (picks.size() == 0 || $urandom_range(0, 3) == 0) return IDX_W'($urandom_range(0, 31));
    return IDX_W'(picks[$urandom_range(0, picks.size() - 1)]);
  endfunction

  function automatic req_t random_get();
    int roll;
    int k;
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
    roll = $urandom_range(0, 99);
    k = $urandom_range(0, TAG_POOL - 1);
    if (roll < 45) begin
      dev = DEV_W'($urandom);
      blk = $urandom_range(0, BLK_TOP);
    end else if (roll < 90) begin
      dev = pool_dev[k];
      blk = pool_blk[k];
    end else begin
      dev = $urandom_range(0, 1) ? '1 : '0;
      blk = $urandom_range(0, 1) ? BLK_TOP : '0;
    end
    return make_word(CMD_GET, dev, blk, IDX_W'($urandom_range(0, 31)), next_now());
  endfunction

  task automatic wait_quiet();
    while (req_backlog.size() != 0 || in_valid_i || reply_due.size() != 0) @(posedge clk_i);
  endtask

  // Input driver: advance on the falling edge after a word was taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (req_backlog.size() > 0 && $urandom_range(0, 99) < gap_pct) begin
        gap_left = $urandom_range(0, 2);
        in_valid_i <= 1'b0;
      end else if (req_backlog.size() > 0) begin
        in_data_i <= req_backlog.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: predict on accept, check each delivered reply against the oldest one due.
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken) reply_due.push_back(predict_reply(in_data_i));
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reply_due.size() == 0) begin
        $error("reply with none due: entry_out %0d status %0d",
               out_data_o.entry_out, out_data_o.status);
        fault_count++;
      end else begin
        want = reply_due.pop_front();
        if (out_data_o.entry_out !== want.entry_out) begin
          $error("entry_out: expected %0d, got %0d", want.entry_out, out_data_o.entry_out);
          fault_count++;
        end
        if (out_data_o.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_data_o.hit);
          fault_count++;
        end
        if (out_data_o.needs_read !== want.needs_read) begin
          $error("needs_read: expected %0d, got %0d", want.needs_read, out_data_o.needs_read);
          fault_count++;
        end
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data_o.status);
          fault_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    int roll;
    int sat_at;
    int level;
    bit drain;
    logic [DEV_W-1:0] sat_dev;
    logic [BLK_W-1:0] sat_blk;
    logic [IDX_W-1:0] sat_idx;

    // a real falling edge, so the asynchronous reset takes hold at once
    rst_ni <= 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      tag_dev[i] = '1;
      tag_blk[i] = '1;
      refs[i] = '0;
      stamp[i] = '0;
      filled[i] = 1'b0;
    end
    for (int i = 0; i < TAG_POOL; i++) begin
      pool_dev[i] = DEV_W'($urandom_range(0, 3));
      pool_blk[i] = $urandom_range(0, BLK_TOP);
    end
    pool_dev[0] = '1;
    pool_blk[0] = BLK_TOP;

    // reset tags are all alike: this one hits entry 0, the lowest match
    req_backlog.push_back(make_word(CMD_GET, '1, '1, '0, 32'd5));
    req_backlog.push_back(make_word(CMD_GET, '0, '0, '0, '0));
    req_backlog.push_back(make_word(CMD_GET, '0, '0, '1, '1));
    req_backlog.push_back(make_word(CMD_VALID, '0, '0, 5'd1, '0));
    req_backlog.push_back(make_word(CMD_GET, '0, '0, '0, 32'd7));
    req_backlog.push_back(make_word(CMD_PIN, '1, '1, 5'd31, 32'd8));
    req_backlog.push_back(make_word(CMD_UNPIN, '1, '1, 5'd31, 32'd9));
    req_backlog.push_back(make_word(CMD_UNPIN, '0, '0, 5'd31, 32'd10));
    req_backlog.push_back(make_word(CMD_RELEASE, '0, '0, 5'd2, 32'd11));
    req_backlog.push_back(make_word(CMD_RELEASE, '0, '0, '0, '1));
    req_backlog.push_back(make_word(CMD_VALID, '0, '0, 5'd30, '0));
    for (int c = 0; c < 3; c++)
      req_backlog.push_back(make_word(3'(CMD_SPARE_A + c), DEV_W'($urandom), $urandom,
                                      IDX_W'($urandom_range(0, 31)), $urandom));
    req_backlog.push_back(make_word(CMD_GET, '1, BLK_TOP, '1, 32'd3));
    req_backlog.push_back(make_word(CMD_GET, 8'haa, 32'h5555_5555, 5'h0a, 32'haaaa_aaaa));
    req_backlog.push_back(make_word(CMD_GET, 8'h55, 32'haaaa_aaaa, 5'h15, 32'h5555_5555));
    req_backlog.push_back(make_word(CMD_PIN, '0, '0, 5'd2, 32'd20));
    req_backlog.push_back(make_word(CMD_RELEASE, '0, '0, 5'd2, 32'd21));
    tick = 32'd100;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int n = 0; n < 1000; n++) begin
      while (req_backlog.size() >= 2) @(posedge clk_i);
      drain = ((n / 150) % 2) == 1;
      if (n >= 700) begin
        gap_pct = 0;
        stall_pct = 0;
      end else if ((n / 100) % 3 == 2) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = 25;
        stall_pct = 30;
      end

      if (n == 300) begin
        // drive one entry to full count and back to zero
        sat_dev = DEV_W'($urandom);
        sat_blk = $urandom_range(0, BLK_TOP);
        req_backlog.push_back(make_word(CMD_GET, sat_dev, sat_blk, '0, next_now()));
        wait_quiet();
        sat_at = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (sat_at < 0 && tag_dev[i] == sat_dev && tag_blk[i] == sat_blk) sat_at = i;
        if (sat_at >= 0 && refs[sat_at] != '0) begin
          sat_idx = IDX_W'(sat_at);
          level = int'(refs[sat_at]);
          for (int k = level; k < CNT_MAX; k++)
            req_backlog.push_back((k % 2) ?
              make_word(CMD_PIN, DEV_W'($urandom), $urandom, sat_idx, next_now()) :
              make_word(CMD_GET, sat_dev, sat_blk, IDX_W'($urandom), next_now()));
          req_backlog.push_back(make_word(CMD_PIN, '0, '0, sat_idx, next_now()));
          req_backlog.push_back(make_word(CMD_GET, sat_dev, sat_blk, '0, next_now()));
          req_backlog.push_back(make_word(CMD_VALID, '0, '0, sat_idx, next_now()));
          for (int k = 0; k < CNT_MAX; k++)
            req_backlog.push_back((k % 2 && k < CNT_MAX - 1) ?
              make_word(CMD_UNPIN, DEV_W'($urandom), $urandom, sat_idx, next_now()) :
              make_word(CMD_RELEASE, DEV_W'($urandom), $urandom, sat_idx, next_now()));
          req_backlog.push_back(make_word(CMD_RELEASE, '0, '0, sat_idx, next_now()));
        end
      end

      roll = $urandom_range(0, 99);
      if (roll < (drain ? 25 : 55))
        req_backlog.push_back(random_get());
      else if (roll < (drain ? 60 : 68))
        req_backlog.push_back(make_word(CMD_RELEASE, DEV_W'($urandom), $urandom,
                                        busy_entry(), next_now()));
      else if (roll < (drain ? 65 : 73))
        req_backlog.push_back(make_word(CMD_PIN, DEV_W'($urandom), $urandom, busy_entry(),
                                        next_now()));
      else if (roll < (drain ? 78 : 80))
        req_backlog.push_back(make_word(CMD_UNPIN, DEV_W'($urandom), $urandom, busy_entry(),
                                        next_now()));
      else if (roll < 95)
        req_backlog.push_back(make_word(CMD_VALID, DEV_W'($urandom), $urandom,
                                        IDX_W'($urandom_range(0, 31)), next_now()));
      else
        req_backlog.push_back(make_word(3'(CMD_SPARE_A + $urandom_range(0, 2)),
                                        DEV_W'($urandom), $urandom,
                                        IDX_W'($urandom_range(0, 31)), $urandom));
    end

    wait_quiet();
    repeat (40) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
